// ===== rtl/core/ptqv_pkg.sv =====
package ptqv_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int FRAC_BITS = 12;
   localparam int NORM_BITS = 30;
   localparam int CSR_ADDR_W = 3;
   localparam int HALF_WIDTH_RESET = 204;
   localparam int TRAIL_LIMIT_RESET = 410;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CAMERA_X     = 3'd0,
      CSR_CAMERA_Y     = 3'd1,
      CSR_CAMERA_Z     = 3'd2,
      CSR_HALF_WIDTH   = 3'd3,
      CSR_ELAPSED_TIME = 3'd4,
      CSR_TRAIL_LIMIT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CORNER_HEAD_MINUS = 2'd0,
      CORNER_HEAD_PLUS  = 2'd1,
      CORNER_TAIL_MINUS = 2'd2,
      CORNER_TAIL_PLUS  = 2'd3
   } corner_type;

endpackage

// ===== rtl/core/ptqv_if.sv =====
interface ptqv_req_if #(parameter int W = ptqv_pkg::COORD_WIDTH);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] pos_x;
   logic signed [W-1:0] pos_y;
   logic signed [W-1:0] pos_z;
   logic signed [W-1:0] vel_x;
   logic signed [W-1:0] vel_y;
   logic signed [W-1:0] vel_z;
   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface ptqv_rsp_if #(parameter int W = ptqv_pkg::COORD_WIDTH);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] vert_x;
   logic signed [W-1:0] vert_y;
   logic signed [W-1:0] vert_z;
   logic [1:0]          corner;
   logic                last_corner;
   logic                degenerate;
   modport source (output valid, vert_x, vert_y, vert_z, corner, last_corner, degenerate,
                   input ready);
   modport sink (input valid, vert_x, vert_y, vert_z, corner, last_corner, degenerate,
                 output ready);
endinterface

interface ptqv_csr_if #(parameter int W = ptqv_pkg::COORD_WIDTH);
   logic                            valid;
   logic                            ready;
   logic [ptqv_pkg::CSR_ADDR_W-1:0] addr;
   logic [W-1:0]                    data;
   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ===== rtl/core/ptqv_emit.sv =====
module ptqv_emit #(
   parameter int W = ptqv_pkg::COORD_WIDTH,
   parameter int TLW = 2 * ptqv_pkg::COORD_WIDTH + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  take,
   input  logic [2:0][W-1:0]     in_pos,
   input  logic [2:0][TLW-1:0]   in_tail,
   input  logic [2:0][W-1:0]     in_off,
   input  logic                  in_degen,
   ptqv_rsp_if.source            rsp_if
);

   localparam logic signed [TLW:0] HI = {{(TLW-W+2){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [TLW:0] LO = ~HI;

   logic                 valid_ff;
   ptqv_pkg::corner_type corner_ff;
   logic [2:0][W-1:0]    pos_ff;
   logic [2:0][TLW-1:0]  tail_ff;
   logic [2:0][W-1:0]    off_ff;
   logic                 degen_ff;
   logic [2:0][W-1:0]    vert;

   assign take = !valid_ff || (rsp_if.ready && corner_ff == ptqv_pkg::CORNER_TAIL_PLUS);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         corner_ff <= ptqv_pkg::CORNER_HEAD_MINUS;
      end else if (take) begin
         valid_ff <= in_valid;
         corner_ff <= ptqv_pkg::CORNER_HEAD_MINUS;
      end else if (rsp_if.ready) begin
         corner_ff <= ptqv_pkg::corner_type'(corner_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pos_ff <= in_pos;
         tail_ff <= in_tail;
         off_ff <= in_off;
         degen_ff <= in_degen;
      end
   end

   always_comb begin
      logic signed [TLW:0] base;
      logic signed [TLW:0] sum;
      for (int k = 0; k < 3; k++) begin
         base = corner_ff[1] ? (TLW+1)'($signed(tail_ff[k])) : (TLW+1)'($signed(pos_ff[k]));
         if (corner_ff[0]) begin
            sum = base + (TLW+1)'($signed(off_ff[k]));
         end else begin
            sum = base - (TLW+1)'($signed(off_ff[k]));
         end
         if (sum > HI) begin
            vert[k] = HI[W-1:0];
         end else if (sum < LO) begin
            vert[k] = LO[W-1:0];
         end else begin
            vert[k] = sum[W-1:0];
         end
      end
   end

   assign rsp_if.valid = valid_ff;
   assign rsp_if.vert_x = vert[0];
   assign rsp_if.vert_y = vert[1];
   assign rsp_if.vert_z = vert[2];
   assign rsp_if.corner = corner_ff;
   assign rsp_if.last_corner = (corner_ff == ptqv_pkg::CORNER_TAIL_PLUS);
   assign rsp_if.degenerate = degen_ff;

endmodule

// ===== rtl/core/particle_trail_quad_vertices_top.sv =====
// particle trail quad vertices
// csr_if: register writes (index, data), always ready; write only while the block is idle.
// req_if: one request per particle (position and velocity, signed Q12.12).
// rsp_if: four vertices per request in corner order head minus, head plus,
// tail minus, tail plus; last_corner marks the fourth, degenerate marks a zero
// cross product (offset forced to zero).
// the datapath is a stall-as-a-whole pipeline: cross products, normalize,
// squares, a square root at two bits per stage and three dividers at two
// quotient bits per stage, then a vertex slot that emits the quad.
// the four vertices share one response channel; requests keep entering
// while the vertex slot drains as long as the last pipeline stage is empty.
// when rsp_if.ready is low the slot holds its vertex and the pipeline stops
// once its last stage is full; nothing is lost or repeated.
// reset (synchronous) clears all valid bits and loads the register defaults.
module particle_trail_quad_vertices_top #(
   parameter int COORD_WIDTH = ptqv_pkg::COORD_WIDTH
) (
   input logic         clock,
   input logic         reset,
   ptqv_csr_if.sink    csr_if,
   ptqv_req_if.sink    req_if,
   ptqv_rsp_if.source  rsp_if
);

   localparam int W = COORD_WIDTH;
   localparam int NB = ptqv_pkg::NORM_BITS;
   localparam int FB = ptqv_pkg::FRAC_BITS;
   localparam int CVW = W + 1;
   localparam int PW = 2 * W + 1;
   localparam int XW = 2 * W + 2;
   localparam int MW = 2 * W + 1;
   localparam int LW = $clog2(MW + 1);
   localparam int TPW = 2 * W;
   localparam int TLW = 2 * W + 1;
   localparam int RW = NB + 2;
   localparam int SQW = 2 * RW;
   localparam int RMW = RW + 2;
   localparam int SQ_STAGES = RW / 2;
   localparam int DNW = W + NB;
   localparam int DIV_BITS = DNW + DNW % 2;
   localparam int DIV_STAGES = DIV_BITS / 2;
   localparam int DRW = RW + 1;
   localparam logic signed [TPW-1:0] RND = TPW'(1) << (FB - 1);

   typedef struct packed {
      logic [2:0][W-1:0]   pos;
      logic [2:0][TLW-1:0] tail;
      logic [2:0]          neg;
      logic                degen;
   } carry_type;

   typedef struct packed {
      logic [RMW-1:0]     rem;
      logic [RW-1:0]      root;
      logic [SQW-1:0]     rad;
      logic [2:0][NB-1:0] c;
      carry_type          car;
   } sqrt_type;

   typedef struct packed {
      logic [2:0][DRW-1:0]      rem;
      logic [2:0][W-1:0]        quo;
      logic [2:0][DIV_BITS-1:0] num;
      logic [RW-1:0]            n;
      carry_type                car;
   } div_type;

   function automatic logic [LW-1:0] bit_len(input logic [MW-1:0] v);
      logic [LW-1:0] n;
      n = '0;
      for (int i = 0; i < MW; i++) begin
         if (v[i]) n = LW'(i + 1);
      end
      return n;
   endfunction

   // registers
   logic [2:0][W-1:0] cam_ff;
   logic [W-2:0]      hw_ff;
   logic [W-2:0]      et_ff;
   logic [W-2:0]      tl_ff;

   logic adv;
   logic take;

   logic                v1_ff;
   logic [2:0][W-1:0]   pos1_ff;
   logic [2:0][W-1:0]   vel1_ff;
   logic [2:0][CVW-1:0] cv1_ff;
   logic [W-2:0]        t1_ff;

   logic                v2_ff;
   logic [5:0][PW-1:0]  pr2_ff;
   logic [2:0][TPW-1:0] tv2_ff;
   logic [2:0][W-1:0]   pos2_ff;

   logic                v3_ff;
   logic [2:0][XW-1:0]  cr3_ff;
   logic [2:0][W-1:0]   pos3_ff;
   logic [2:0][TLW-1:0] tail3_ff;

   logic               v4_ff;
   logic [2:0][MW-1:0] mag4_ff;
   carry_type          car4_ff;

   logic               v5_ff;
   logic [LW-1:0]      len5_ff;
   logic [2:0][MW-1:0] mag5_ff;
   carry_type          car5_ff;

   logic               v6_ff;
   logic [2:0][NB-1:0] c6_ff;
   carry_type          car6_ff;

   logic                 v7_ff;
   logic [2:0][2*NB-1:0] sqr7_ff;
   logic [2:0][NB-1:0]   c7_ff;
   carry_type            car7_ff;

   logic     v8_ff;
   sqrt_type sq0_ff;

   logic [SQ_STAGES:1] sqv_ff;
   sqrt_type           sqs_ff [1:SQ_STAGES];
   sqrt_type           sq_in  [1:SQ_STAGES];

   logic    dv0_v_ff;
   div_type dv0_ff;

   logic [DIV_STAGES:1] dvv_ff;
   div_type             dvs_ff [1:DIV_STAGES];
   div_type             dv_in  [1:DIV_STAGES];

   logic [2:0][W-1:0] off;

   // configuration
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff <= '0;
         hw_ff <= (W-1)'(ptqv_pkg::HALF_WIDTH_RESET);
         et_ff <= '0;
         tl_ff <= (W-1)'(ptqv_pkg::TRAIL_LIMIT_RESET);
      end else if (csr_if.valid) begin
         case (ptqv_pkg::csr_index_type'(csr_if.addr))
            ptqv_pkg::CSR_CAMERA_X: begin
               cam_ff[0] <= csr_if.data;
            end
            ptqv_pkg::CSR_CAMERA_Y: begin
               cam_ff[1] <= csr_if.data;
            end
            ptqv_pkg::CSR_CAMERA_Z: begin
               cam_ff[2] <= csr_if.data;
            end
            ptqv_pkg::CSR_HALF_WIDTH: begin
               hw_ff <= csr_if.data[W-2:0];
            end
            ptqv_pkg::CSR_ELAPSED_TIME: begin
               et_ff <= csr_if.data[W-2:0];
            end
            ptqv_pkg::CSR_TRAIL_LIMIT: begin
               tl_ff <= csr_if.data[W-2:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign adv = !dvv_ff[DIV_STAGES] || take;
   assign req_if.ready = adv;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         sqv_ff <= '0;
         dv0_v_ff <= 1'b0;
         dvv_ff <= '0;
      end else if (adv) begin
         v1_ff <= req_if.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         sqv_ff[1] <= v8_ff;
         for (int g = 2; g <= SQ_STAGES; g++) sqv_ff[g] <= sqv_ff[g-1];
         dv0_v_ff <= sqv_ff[SQ_STAGES];
         dvv_ff[1] <= dv0_v_ff;
         for (int g = 2; g <= DIV_STAGES; g++) dvv_ff[g] <= dvv_ff[g-1];
      end
   end

   // operands, cross product terms, trail product, tail, magnitudes
   always_ff @(posedge clock) begin
      if (adv) begin
         pos1_ff[0] <= req_if.pos_x;
         pos1_ff[1] <= req_if.pos_y;
         pos1_ff[2] <= req_if.pos_z;
         vel1_ff[0] <= req_if.vel_x;
         vel1_ff[1] <= req_if.vel_y;
         vel1_ff[2] <= req_if.vel_z;
         cv1_ff[0] <= CVW'(req_if.pos_x) - CVW'($signed(cam_ff[0]));
         cv1_ff[1] <= CVW'(req_if.pos_y) - CVW'($signed(cam_ff[1]));
         cv1_ff[2] <= CVW'(req_if.pos_z) - CVW'($signed(cam_ff[2]));
         t1_ff <= (et_ff < tl_ff) ? et_ff : tl_ff;

         pr2_ff[0] <= PW'($signed(vel1_ff[1])) * PW'($signed(cv1_ff[2]));
         pr2_ff[1] <= PW'($signed(vel1_ff[2])) * PW'($signed(cv1_ff[1]));
         pr2_ff[2] <= PW'($signed(vel1_ff[2])) * PW'($signed(cv1_ff[0]));
         pr2_ff[3] <= PW'($signed(vel1_ff[0])) * PW'($signed(cv1_ff[2]));
         pr2_ff[4] <= PW'($signed(vel1_ff[0])) * PW'($signed(cv1_ff[1]));
         pr2_ff[5] <= PW'($signed(vel1_ff[1])) * PW'($signed(cv1_ff[0]));
         for (int k = 0; k < 3; k++) begin
            tv2_ff[k] <= TPW'($signed({1'b0, t1_ff})) * TPW'($signed(vel1_ff[k]));
         end
         pos2_ff <= pos1_ff;

         for (int k = 0; k < 3; k++) begin
            cr3_ff[k] <= XW'($signed(pr2_ff[2*k])) - XW'($signed(pr2_ff[2*k+1]));
            tail3_ff[k] <= TLW'($signed(pos2_ff[k]))
                           - TLW'(($signed(tv2_ff[k]) + RND) >>> FB);
         end
         pos3_ff <= pos2_ff;

         for (int k = 0; k < 3; k++) begin
            car4_ff.neg[k] <= cr3_ff[k][XW-1];
            mag4_ff[k] <= cr3_ff[k][XW-1] ? MW'(-$signed(cr3_ff[k])) : MW'(cr3_ff[k]);
         end
         car4_ff.pos <= pos3_ff;
         car4_ff.tail <= tail3_ff;
         car4_ff.degen <= 1'b0;
      end
   end

   // normalize to a common scale, squares, sum
   always_ff @(posedge clock) begin
      if (adv) begin
         len5_ff <= bit_len(mag4_ff[0] | mag4_ff[1] | mag4_ff[2]);
         mag5_ff <= mag4_ff;
         car5_ff.pos <= car4_ff.pos;
         car5_ff.tail <= car4_ff.tail;
         car5_ff.neg <= car4_ff.neg;
         car5_ff.degen <= ((mag4_ff[0] | mag4_ff[1] | mag4_ff[2]) == '0);

         for (int k = 0; k < 3; k++) begin
            if (len5_ff > LW'(NB)) begin
               c6_ff[k] <= NB'(mag5_ff[k] >> (len5_ff - LW'(NB)));
            end else begin
               c6_ff[k] <= NB'(mag5_ff[k] << (LW'(NB) - len5_ff));
            end
         end
         car6_ff <= car5_ff;

         for (int k = 0; k < 3; k++) begin
            sqr7_ff[k] <= (2*NB)'(c6_ff[k]) * (2*NB)'(c6_ff[k]);
         end
         c7_ff <= c6_ff;
         car7_ff <= car6_ff;

         sq0_ff.rem <= '0;
         sq0_ff.root <= '0;
         sq0_ff.rad <= SQW'(sqr7_ff[0]) + SQW'(sqr7_ff[1]) + SQW'(sqr7_ff[2]);
         sq0_ff.c <= c7_ff;
         sq0_ff.car <= car7_ff;
      end
   end

   // square root, two result bits per stage
   always_comb begin
      logic [RMW-1:0] r2;
      logic [RMW-1:0] trial;
      for (int g = 1; g <= SQ_STAGES; g++) begin
         sq_in[g] = (g == 1) ? sq0_ff : sqs_ff[g-1];
         for (int i = 0; i < 2; i++) begin
            r2 = {sq_in[g].rem[RMW-3:0], sq_in[g].rad[SQW-1 -: 2]};
            trial = {sq_in[g].root, 2'b01};
            sq_in[g].rad = sq_in[g].rad << 2;
            if (r2 >= trial) begin
               sq_in[g].rem = r2 - trial;
               sq_in[g].root = {sq_in[g].root[RW-2:0], 1'b1};
            end else begin
               sq_in[g].rem = r2;
               sq_in[g].root = {sq_in[g].root[RW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int g = 1; g <= SQ_STAGES; g++) sqs_ff[g] <= sq_in[g];
      end
   end

   // dividend: half width times component plus half the norm
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            dv0_ff.num[k] <= DIV_BITS'(DNW'(hw_ff) * DNW'(sqs_ff[SQ_STAGES].c[k])
                                       + DNW'(sqs_ff[SQ_STAGES].root >> 1));
         end
         dv0_ff.rem <= '0;
         dv0_ff.quo <= '0;
         dv0_ff.n <= sqs_ff[SQ_STAGES].root;
         dv0_ff.car <= sqs_ff[SQ_STAGES].car;
      end
   end

   // three restoring dividers, two quotient bits per stage
   always_comb begin
      logic [DRW-1:0] r2;
      logic           qb;
      for (int g = 1; g <= DIV_STAGES; g++) begin
         dv_in[g] = (g == 1) ? dv0_ff : dvs_ff[g-1];
         for (int i = 0; i < 2; i++) begin
            for (int k = 0; k < 3; k++) begin
               r2 = {dv_in[g].rem[k][DRW-2:0], dv_in[g].num[k][DIV_BITS-1]};
               dv_in[g].num[k] = dv_in[g].num[k] << 1;
               qb = (r2 >= DRW'(dv_in[g].n));
               dv_in[g].rem[k] = qb ? (r2 - DRW'(dv_in[g].n)) : r2;
               dv_in[g].quo[k] = {dv_in[g].quo[k][W-2:0], qb};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int g = 1; g <= DIV_STAGES; g++) dvs_ff[g] <= dv_in[g];
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dvs_ff[DIV_STAGES].car.degen) begin
            off[k] = '0;
         end else if (dvs_ff[DIV_STAGES].car.neg[k]) begin
            off[k] = -dvs_ff[DIV_STAGES].quo[k];
         end else begin
            off[k] = dvs_ff[DIV_STAGES].quo[k];
         end
      end
   end

   ptqv_emit #(
      .W   (W),
      .TLW (TLW)
   ) u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dvv_ff[DIV_STAGES]),
      .take     (take),
      .in_pos   (dvs_ff[DIV_STAGES].car.pos),
      .in_tail  (dvs_ff[DIV_STAGES].car.tail),
      .in_off   (off),
      .in_degen (dvs_ff[DIV_STAGES].car.degen),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== rtl/core/ptqv_checker.sv =====
module ptqv_checker #(
   parameter int W = ptqv_pkg::COORD_WIDTH
) (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [W-1:0] vert_x,
   input logic [W-1:0] vert_y,
   input logic [W-1:0] vert_z,
   input logic [1:0]   corner,
   input logic         last_corner,
   input logic         degenerate
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(vert_x) && $stable(vert_y)
         && $stable(vert_z) && $stable(corner) && $stable(degenerate))
      else $error("response changed while stalled");

   a_next_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_corner |=> rsp_valid
         && corner == $past(corner) + 2'd1)
      else $error("quad corners not contiguous");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> last_corner == (corner == ptqv_pkg::CORNER_TAIL_PLUS))
      else $error("last_corner does not match corner");

   a_degen_quad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_corner |=> degenerate == $past(degenerate))
      else $error("degenerate flag changed within a quad");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind particle_trail_quad_vertices_top ptqv_checker #(.W(COORD_WIDTH)) u_ptqv_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .vert_x      (rsp_if.vert_x),
   .vert_y      (rsp_if.vert_y),
   .vert_z      (rsp_if.vert_z),
   .corner      (rsp_if.corner),
   .last_corner (rsp_if.last_corner),
   .degenerate  (rsp_if.degenerate)
);

// ===== verif/particle_trail_quad_vertices_top_test.sv =====
module particle_trail_quad_vertices_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = ptqv_pkg::COORD_WIDTH;
   localparam int AW = ptqv_pkg::CSR_ADDR_W;
   localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-2:0] U_MAX = {(W-1){1'b1}};
   localparam logic [AW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [AW-1:0] CSR_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_LIMIT = 4000;
   localparam int NUM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 56;

   typedef struct {
      logic signed [W-1:0] p[3];
      logic signed [W-1:0] v[3];
   } particle_type;

   typedef struct {
      particle_type part;
      logic         still;
   } directed_row_type;

   typedef struct {
      logic signed [W-1:0]  x;
      logic signed [W-1:0]  y;
      logic signed [W-1:0]  z;
      ptqv_pkg::corner_type corner;
      logic                 last;
      logic                 degen;
   } vertex_type;

   logic clock;
   logic reset;

   ptqv_csr_if #(.W(W)) csr_bus ();
   ptqv_req_if #(.W(W)) req_bus ();
   ptqv_rsp_if #(.W(W)) rsp_bus ();

   particle_trail_quad_vertices_top #(.COORD_WIDTH(W)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_bus),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   logic signed [W-1:0] cam_pos[3];
   logic [W-2:0]        half_w;
   logic [W-2:0]        elapsed;
   logic [W-2:0]        trail_max;

   vertex_type vertex_q[$];
   int         error_count;
   int         idle_cycles;
   bit         calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int draw_wait();
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   function automatic logic signed [W-1:0] sat_coord(longint v);
      if (v > longint'(C_MAX)) return C_MAX;
      if (v < longint'(C_MIN)) return C_MIN;
      return v[W-1:0];
   endfunction

   // expected quad for one particle under the current register settings
   task automatic predict_quad(particle_type pt);
      longint          pp[3], vv[3], rel[3], tail[3], xprod[3], off[3], base[3];
      longint unsigned mag[3], cn[3], sq, root, bitv, q;
      longint          t, step;
      int              maxlen, len, s;
      logic            degen;
      vertex_type      vx;
      t = (elapsed < trail_max) ? longint'(elapsed) : longint'(trail_max);
      for (int k = 0; k < 3; k++) begin
         pp[k] = longint'(pt.p[k]);
         vv[k] = longint'(pt.v[k]);
         rel[k] = pp[k] - longint'(cam_pos[k]);
         step = (t * vv[k] + 2048) >>> ptqv_pkg::FRAC_BITS;
         tail[k] = pp[k] - step;
      end
      xprod[0] = vv[1] * rel[2] - vv[2] * rel[1];
      xprod[1] = vv[2] * rel[0] - vv[0] * rel[2];
      xprod[2] = vv[0] * rel[1] - vv[1] * rel[0];
      maxlen = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = (xprod[k] < 0) ? longint'(-xprod[k]) : longint'(xprod[k]);
         len = 0;
         for (int b = 0; b < 64; b++) if (mag[k][b]) len = b + 1;
         if (len > maxlen) maxlen = len;
      end
      degen = (maxlen == 0);
      for (int k = 0; k < 3; k++) off[k] = 0;
      if (!degen) begin
         s = maxlen - ptqv_pkg::NORM_BITS;
         sq = 0;
         for (int k = 0; k < 3; k++) begin
            cn[k] = (s >= 0) ? (mag[k] >> s) : (mag[k] << (-s));
            sq += cn[k] * cn[k];
         end
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > sq) bitv >>= 2;
         while (bitv != 0) begin
            if (sq >= root + bitv) begin
               sq -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         for (int k = 0; k < 3; k++) begin
            q = (longint'(half_w) * cn[k] + (root >> 1)) / root;
            off[k] = (xprod[k] < 0) ? -longint'(q) : longint'(q);
         end
      end
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 3; k++) begin
            base[k] = (j < 2) ? pp[k] : tail[k];
            base[k] = j[0] ? base[k] + off[k] : base[k] - off[k];
         end
         vx.x = sat_coord(base[0]);
         vx.y = sat_coord(base[1]);
         vx.z = sat_coord(base[2]);
         vx.corner = ptqv_pkg::corner_type'(j[1:0]);
         vx.last = (j == 3);
         vx.degen = degen;
         vertex_q.push_back(vx);
      end
   endtask

   // motionless particle: all four corners sit on the position
   task automatic push_still_quad(particle_type pt);
      vertex_type vx;
      for (int j = 0; j < 4; j++) begin
         vx.x = pt.p[0];
         vx.y = pt.p[1];
         vx.z = pt.p[2];
         vx.corner = ptqv_pkg::corner_type'(j[1:0]);
         vx.last = (j == 3);
         vx.degen = 1'b1;
         vertex_q.push_back(vx);
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      error_count++;
   endtask

   task automatic write_csr(logic [AW-1:0] addr, logic [W-1:0] data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.addr = addr;
      csr_bus.data = data;
      do @(posedge clock); while (!csr_bus.ready);
      case (addr)
         ptqv_pkg::CSR_CAMERA_X:     cam_pos[0] = data;
         ptqv_pkg::CSR_CAMERA_Y:     cam_pos[1] = data;
         ptqv_pkg::CSR_CAMERA_Z:     cam_pos[2] = data;
         ptqv_pkg::CSR_HALF_WIDTH:   half_w = data[W-2:0];
         ptqv_pkg::CSR_ELAPSED_TIME: elapsed = data[W-2:0];
         ptqv_pkg::CSR_TRAIL_LIMIT:  trail_max = data[W-2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (vertex_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_particle(particle_type pt, logic still);
      int gap;
      gap = draw_wait();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.pos_x = pt.p[0];
      req_bus.pos_y = pt.p[1];
      req_bus.pos_z = pt.p[2];
      req_bus.vel_x = pt.v[0];
      req_bus.vel_y = pt.v[1];
      req_bus.vel_z = pt.v[2];
      do @(posedge clock); while (!req_bus.ready);
      if (still) push_still_quad(pt);
      else predict_quad(pt);
   endtask

   task automatic end_request();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   function automatic logic [W-1:0] rand_word();
      return W'($urandom());
   endfunction

   function automatic particle_type random_particle();
      particle_type pt;
      int           kind;
      int           mult;
      int           pick;
      longint       r;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) begin
         case (kind)
            0, 1, 2, 3: begin
               pt.p[k] = rand_word();
               pt.v[k] = rand_word();
            end
            4, 5, 6: begin
               pt.p[k] = W'($signed($urandom_range(0, 65535)) - 32768);
               pt.v[k] = W'($signed($urandom_range(0, 32767)) - 16384);
            end
            7: begin
               pt.p[k] = ($urandom_range(0, 1) == 0) ? C_MAX : C_MIN;
               pt.v[k] = ($urandom_range(0, 2) == 0) ? '0 : rand_word();
            end
            default: begin
               pt.p[k] = W'($signed($urandom_range(0, 16383)) - 8192
                            + longint'(cam_pos[k]));
               pt.v[k] = '0;
            end
         endcase
      end
      if (kind >= 8) begin
         // velocity along the camera ray gives a zero cross product
         mult = $urandom_range(1, 3);
         for (int k = 0; k < 3; k++) begin
            r = (longint'(pt.p[k]) - longint'(cam_pos[k])) * mult;
            pt.v[k] = r[W-1:0];
         end
         if (kind == 9 && $urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 2);
            pt.v[pick] = pt.v[pick] + W'(1);
         end
      end
      return pt;
   endfunction

   task automatic setup_phase(int ph);
      logic [W-1:0] val[6];
      case (ph)
         1: begin
            val = '{C_MAX, C_MAX, C_MAX, {1'b0, U_MAX}, {1'b0, U_MAX}, {1'b0, U_MAX}};
         end
         2: begin
            val = '{C_MIN, C_MIN, C_MIN, '0, '0, '0};
         end
         3: begin
            val = '{24'd4096, -24'sd8192, 24'd300, 24'd204, 24'd8192, 24'd20000};
         end
         4: begin
            val = '{'0, '0, '0, {1'b0, U_MAX}, 24'd500, {1'b0, U_MAX}};
         end
         default: begin
            for (int k = 0; k < 6; k++) val[k] = rand_word();
            if (ph % 2 == 0) begin
               val[4] = W'($urandom_range(0, 16384));
               val[5] = W'($urandom_range(0, 16384));
            end
         end
      endcase
      // unsigned registers get stray top bits that must be dropped
      for (int k = 3; k < 6; k++) val[k][W-1] = 1'($urandom_range(0, 1));
      write_csr(ptqv_pkg::CSR_CAMERA_X, val[0]);
      write_csr(ptqv_pkg::CSR_CAMERA_Y, val[1]);
      write_csr(ptqv_pkg::CSR_CAMERA_Z, val[2]);
      write_csr(ptqv_pkg::CSR_HALF_WIDTH, val[3]);
      write_csr(ptqv_pkg::CSR_ELAPSED_TIME, val[4]);
      write_csr(ptqv_pkg::CSR_TRAIL_LIMIT, val[5]);
      write_csr(($urandom_range(0, 1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI, rand_word());
   endtask

   // response side
   initial begin
      vertex_type want;
      int         n;
      rsp_bus.ready = 1'b0;
      forever begin
         n = draw_wait();
         repeat (n) begin
            @(negedge clock);
            rsp_bus.ready = 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready = 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1) || reset);
         if (vertex_q.size() == 0) begin
            report_mismatch("vertex with no request pending", rsp_bus.corner, -1);
         end else begin
            want = vertex_q.pop_front();
            if (rsp_bus.vert_x !== want.x) report_mismatch("vert_x", rsp_bus.vert_x, want.x);
            if (rsp_bus.vert_y !== want.y) report_mismatch("vert_y", rsp_bus.vert_y, want.y);
            if (rsp_bus.vert_z !== want.z) report_mismatch("vert_z", rsp_bus.vert_z, want.z);
            if (rsp_bus.corner !== want.corner)
               report_mismatch("corner", rsp_bus.corner, want.corner);
            if (rsp_bus.last_corner !== want.last)
               report_mismatch("last_corner", rsp_bus.last_corner, want.last);
            if (rsp_bus.degenerate !== want.degen)
               report_mismatch("degenerate", rsp_bus.degenerate, want.degen);
         end
      end
   end

   // watchdog on cycles with no request, vertex or register write moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      directed_row_type rows[10];
      int               pause_at;
      error_count = 0;
      idle_cycles = 0;
      calm = 1'b0;
      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.addr = '0;
      csr_bus.data = '0;
      req_bus.valid = 1'b0;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.vel_x = '0;
      req_bus.vel_y = '0;
      req_bus.vel_z = '0;
      for (int k = 0; k < 3; k++) cam_pos[k] = '0;
      half_w = (W-1)'(ptqv_pkg::HALF_WIDTH_RESET);
      elapsed = '0;
      trail_max = (W-1)'(ptqv_pkg::TRAIL_LIMIT_RESET);

      rows[0] = '{'{'{24'd0, 24'd0, 24'd0}, '{24'd0, 24'd0, 24'd0}}, 1'b1};
      rows[1] = '{'{'{C_MAX, C_MAX, C_MAX}, '{24'd0, 24'd0, 24'd0}}, 1'b1};
      rows[2] = '{'{'{C_MIN, C_MIN, C_MIN}, '{24'd0, 24'd0, 24'd0}}, 1'b1};
      rows[3] = '{'{'{24'd4096, -24'sd4096, 24'd8192}, '{24'd0, 24'd0, 24'd0}}, 1'b1};
      // parallel to the camera ray, trail zero after reset
      rows[4] = '{'{'{24'd4096, 24'd4096, 24'd4096}, '{24'd8192, 24'd8192, 24'd8192}}, 1'b1};
      rows[5] = '{'{'{24'd4096, 24'd0, 24'd0}, '{24'd0, 24'd4096, 24'd0}}, 1'b0};
      rows[6] = '{'{'{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MAX, C_MIN}}, 1'b0};
      rows[7] = '{'{'{C_MIN, C_MAX, C_MIN}, '{C_MAX, C_MIN, C_MAX}}, 1'b0};
      rows[8] = '{'{'{C_MAX, C_MIN, 24'd1}, '{C_MIN, C_MIN, C_MIN}}, 1'b0};
      rows[9] = '{'{'{24'd1, -24'sd1, 24'd0}, '{24'd1, 24'd1, -24'sd1}}, 1'b0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_particle(rows[i].part, rows[i].still);
      end_request();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         if (ph > 0) setup_phase(ph);
         calm = (ph % 3 == 2);
         pause_at = $urandom_range(5, ITEMS_PER_PHASE - 5);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i == pause_at) begin
               end_request();
               while (vertex_q.size() != 0) @(posedge clock);
            end
            send_particle(random_particle(), 1'b0);
         end
         end_request();
      end

      wait_drained();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
